// ===== rtl/cmcpa_pkg.sv =====
// shared constants of the caplet payoff averager
package cmcpa_pkg;

	localparam int unsigned MAX_TENORS = 64;
	localparam int unsigned MAX_PATHS  = 32768;
	localparam int unsigned PATH_CAP   = (MAX_PATHS > 65535) ? 65535 : MAX_PATHS;

	localparam logic [47:0] PRICE_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [36:0] ONE_Q30   = 37'h0_4000_0000;

	localparam logic [2:0] REG_STRIKE   = 3'd0;
	localparam logic [2:0] REG_ACCRUAL  = 3'd1;
	localparam logic [2:0] REG_INITIAL  = 3'd2;
	localparam logic [2:0] REG_MATURITY = 3'd3;
	localparam logic [2:0] REG_TENORS   = 3'd4;

	localparam logic [31:0] ACCRUAL_RESET = 32'h1000_0000;
	localparam logic [6:0]  TENORS_RESET  = 7'd8;

endpackage

// ===== rtl/caplet_monte_carlo_payoff_average.sv =====
// caplet monte carlo payoff averager: top level with shared multiplier and divider
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata prev_rate, rate; tlast path_end; tuser batch_end
//  m_*       out  m_tvalid/m_tready  tdata price; tuser saturated
//  cfg_*     in   cfg_we             cfg_index register, cfg_data value
//
// a rate beat is accepted in the idle state, then runs payoff, growth factor and compounding,
// each a pass of the shared 24x36 multiplier or a skip, then the path update; a batch end
// adds the count check, the discount base, the path average division and the discount
// divisions per tenor (one bit a cycle) and the load of the output register, which waits
// while the previous price is still held
// s_tready is high only when the sequencer is idle; arst_n clears all state and loads defaults

module caplet_monte_carlo_payoff_average (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] prev_rate, [63:32] rate
	input  logic        s_tlast,   // path_end
	input  logic        s_tuser,   // batch_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [47:0] price
	output logic        m_tuser,   // saturated
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PAY   = 4'd1;
	localparam logic [3:0] ST_GROW  = 4'd2;
	localparam logic [3:0] ST_CMP   = 4'd3;
	localparam logic [3:0] ST_PATH  = 4'd4;
	localparam logic [3:0] ST_BATCH = 4'd5;
	localparam logic [3:0] ST_BASE  = 4'd6;
	localparam logic [3:0] ST_AVG   = 4'd7;
	localparam logic [3:0] ST_DISC  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	// configuration registers
	logic signed [31:0] strike_q;
	logic [31:0]        accr_q;
	logic signed [31:0] init_q;
	logic [5:0]         mat_q;
	logic [6:0]         tc_q;

	// sequencer and path state
	logic [3:0]         state_q;
	logic [5:0]         ei_q;
	logic               overrun_q;
	logic [47:0]        pp_q;
	logic [63:0]        sum_q;
	logic [15:0]        count_q;
	logic               flag_q;

	// latched beat
	logic signed [32:0] diff_q;
	logic [31:0]        rmag_q;
	logic               rneg_q;
	logic               pend_q;
	logic               bend_q;

	// shared multiplier
	logic [1:0]         mstep_q;
	logic [83:0]        macc_q;
	logic [47:0]        mul_a;
	logic [35:0]        mul_b;
	logic [23:0]        mul_part;
	logic [59:0]        mul_prod;

	// growth factor and discount base
	logic signed [36:0] f_q;
	logic [35:0]        base_q;
	logic [35:0]        term;
	logic signed [36:0] f_new;
	logic               f_neg_sel;

	// shared divider
	logic [93:0]        num_q;
	logic [35:0]        rem_q;
	logic [35:0]        dvs_q;
	logic [6:0]         dcnt_q;
	logic [6:0]         tl_q;
	logic [63:0]        res_q;
	logic [36:0]        rem_sh;
	logic               take;
	logic [35:0]        rem_nx;
	logic [93:0]        num_nx;
	logic [63:0]        disc_p;
	logic               disc_sat;

	// output register
	logic               m_valid_q;
	logic [47:0]        price_q;
	logic               sat_q;
	logic               out_load;

	logic [6:0]         tenors;
	logic               window;
	logic [64:0]        sum_add;
	logic [31:0]        imag;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = price_q;
	assign m_tuser  = sat_q;

	// price moves into the output register once that register is free
	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	// tenor counts above the limit act as the limit
	assign tenors = (tc_q > 7'(cmcpa_pkg::MAX_TENORS)) ? 7'(cmcpa_pkg::MAX_TENORS) : tc_q;
	assign window = !overrun_q && (ei_q >= mat_q) && ({1'b0, ei_q} < tenors);
	assign imag   = init_q[31] ? (~init_q + 32'd1) : init_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = {4'd0, accr_q};
		f_neg_sel = rneg_q;
		unique case (state_q)
			ST_PAY:  mul_a = {16'd0, diff_q[31:0]};
			ST_GROW: mul_a = {16'd0, rmag_q};
			ST_CMP: begin
				mul_a = pp_q;
				mul_b = f_q[35:0];
			end
			ST_BASE: begin
				mul_a = {16'd0, imag};
				f_neg_sel = init_q[31];
			end
			default: mul_a = '0;
		endcase
	end

	assign mul_part = (mstep_q == 2'd0) ? mul_a[23:0] : mul_a[47:24];
	assign mul_prod = {36'd0, mul_part} * {24'd0, mul_b};

	// 1 + rate * accrual in q6.30
	assign term  = macc_q[63:28];
	assign f_new = f_neg_sel ? (cmcpa_pkg::ONE_Q30 - {1'b0, term})
	                         : (cmcpa_pkg::ONE_Q30 + {1'b0, term});

	// restoring divide, one quotient bit a cycle
	assign rem_sh = {rem_q, num_q[93]};
	assign take   = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx = take ? 36'(rem_sh - {1'b0, dvs_q}) : rem_sh[35:0];
	assign num_nx = {num_q[92:0], take};
	assign disc_sat = (num_nx[93:64] != '0);
	assign disc_p   = disc_sat ? 64'hFFFF_FFFF_FFFF_FFFF : num_nx[63:0];

	assign sum_add = {1'b0, sum_q} + {17'd0, pp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strike_q  <= '0;
			accr_q    <= cmcpa_pkg::ACCRUAL_RESET;
			init_q    <= '0;
			mat_q     <= '0;
			tc_q      <= cmcpa_pkg::TENORS_RESET;
			state_q   <= ST_IDLE;
			ei_q      <= '0;
			overrun_q <= 1'b0;
			pp_q      <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			flag_q    <= 1'b0;
			diff_q    <= '0;
			rmag_q    <= '0;
			rneg_q    <= 1'b0;
			pend_q    <= 1'b0;
			bend_q    <= 1'b0;
			mstep_q   <= '0;
			macc_q    <= '0;
			f_q       <= '0;
			base_q    <= '0;
			num_q     <= '0;
			rem_q     <= '0;
			dvs_q     <= '0;
			dcnt_q    <= '0;
			tl_q      <= '0;
			res_q     <= '0;
			m_valid_q <= 1'b0;
			price_q   <= '0;
			sat_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cmcpa_pkg::REG_STRIKE:   strike_q <= cfg_data;
					cmcpa_pkg::REG_ACCRUAL:  accr_q   <= cfg_data;
					cmcpa_pkg::REG_INITIAL:  init_q   <= cfg_data;
					cmcpa_pkg::REG_MATURITY: mat_q    <= cfg_data[5:0];
					cmcpa_pkg::REG_TENORS:   tc_q     <= cfg_data[6:0];
					default: ;
				endcase
			end

			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;

			// multiplier passes: low half, then high half shifted by 24
			if (mstep_q == 2'd0)
				macc_q <= {24'd0, mul_prod};
			else if (mstep_q == 2'd1)
				macc_q <= macc_q + {mul_prod, 24'd0};

			unique case (state_q)
				ST_IDLE: begin
					mstep_q <= 2'd0;
					if (s_tvalid) begin
						diff_q  <= {s_tdata[31], s_tdata[31:0]} - {strike_q[31], strike_q};
						rneg_q  <= s_tdata[63];
						rmag_q  <= s_tdata[63] ? (~s_tdata[63:32] + 32'd1) : s_tdata[63:32];
						pend_q  <= s_tlast;
						bend_q  <= s_tuser;
						state_q <= ST_PAY;
					end
				end
				// payoff on the first element of a path
				ST_PAY: begin
					if (overrun_q || ei_q != '0) begin
						mstep_q <= 2'd0;
						state_q <= ST_GROW;
					end else if (diff_q[32] || diff_q == '0) begin
						pp_q    <= '0;
						mstep_q <= 2'd0;
						state_q <= ST_GROW;
					end else if (mstep_q == 2'd2) begin
						pp_q    <= macc_q[65:18];
						mstep_q <= 2'd0;
						state_q <= ST_GROW;
					end else begin
						mstep_q <= mstep_q + 2'd1;
					end
				end
				ST_GROW: begin
					if (!window) begin
						state_q <= ST_PATH;
					end else if (mstep_q == 2'd2) begin
						f_q     <= f_new;
						mstep_q <= 2'd0;
						state_q <= ST_CMP;
					end else begin
						mstep_q <= mstep_q + 2'd1;
					end
				end
				// compound the path value, clamp negative growth, saturate overflow
				ST_CMP: begin
					if (f_q[36] || f_q == '0) begin
						if (f_q[36] && pp_q != '0)
							flag_q <= 1'b1;
						pp_q    <= '0;
						state_q <= ST_PATH;
					end else if (mstep_q == 2'd2) begin
						if (macc_q[83:78] != '0) begin
							pp_q   <= cmcpa_pkg::PRICE_MAX;
							flag_q <= 1'b1;
						end else begin
							pp_q <= macc_q[77:30];
						end
						mstep_q <= 2'd0;
						state_q <= ST_PATH;
					end else begin
						mstep_q <= mstep_q + 2'd1;
					end
				end
				ST_PATH: begin
					if (pend_q || bend_q) begin
						if (count_q >= 16'(cmcpa_pkg::PATH_CAP)) begin
							flag_q <= 1'b1;
						end else begin
							if (sum_add[64]) begin
								sum_q  <= 64'hFFFF_FFFF_FFFF_FFFF;
								flag_q <= 1'b1;
							end else begin
								sum_q <= sum_add[63:0];
							end
							count_q <= count_q + 16'd1;
						end
						ei_q      <= '0;
						overrun_q <= 1'b0;
						pp_q      <= '0;
					end else if (!overrun_q) begin
						if (ei_q == 6'd63)
							overrun_q <= 1'b1;
						else
							ei_q <= ei_q + 6'd1;
					end
					mstep_q <= 2'd0;
					state_q <= bend_q ? ST_BATCH : ST_IDLE;
				end
				ST_BATCH: begin
					mstep_q <= 2'd0;
					if (count_q == '0) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_BASE;
					end
				end
				// discount base, then load the path average division, or saturate on a non-positive base
				ST_BASE: begin
					if (mstep_q == 2'd2) begin
						mstep_q <= 2'd0;
						if (f_new[36] || f_new == '0) begin
							res_q   <= 64'hFFFF_FFFF_FFFF_FFFF;
							flag_q  <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							base_q  <= f_new[35:0];
							num_q   <= {sum_q, 30'd0};
							rem_q   <= '0;
							dvs_q   <= {20'd0, count_q};
							dcnt_q  <= 7'd64;
							tl_q    <= tenors;
							state_q <= ST_AVG;
						end
					end else begin
						mstep_q <= mstep_q + 2'd1;
					end
				end
				ST_AVG: begin
					if (dcnt_q == 7'd1) begin
						if (tl_q == '0) begin
							res_q   <= num_nx[63:0];
							state_q <= ST_OUT;
						end else begin
							num_q   <= {num_nx[63:0], 30'd0};
							rem_q   <= '0;
							dvs_q   <= base_q;
							dcnt_q  <= 7'd94;
							state_q <= ST_DISC;
						end
					end else begin
						num_q  <= num_nx;
						rem_q  <= rem_nx;
						dcnt_q <= dcnt_q - 7'd1;
					end
				end
				// one divide by the discount base per tenor
				ST_DISC: begin
					if (dcnt_q == 7'd1) begin
						if (disc_sat)
							flag_q <= 1'b1;
						tl_q <= tl_q - 7'd1;
						if (tl_q == 7'd1) begin
							res_q   <= disc_p;
							state_q <= ST_OUT;
						end else begin
							num_q  <= {disc_p, 30'd0};
							rem_q  <= '0;
							dcnt_q <= 7'd94;
						end
					end else begin
						num_q  <= num_nx;
						rem_q  <= rem_nx;
						dcnt_q <= dcnt_q - 7'd1;
					end
				end
				// hand over to the output register once it is free, clear batch state
				ST_OUT: begin
					if (out_load) begin
						if (res_q[63:48] != '0) begin
							price_q <= cmcpa_pkg::PRICE_MAX;
							sat_q   <= 1'b1;
						end else begin
							price_q <= res_q[47:0];
							sat_q   <= flag_q;
						end
						ei_q      <= '0;
						overrun_q <= 1'b0;
						pp_q      <= '0;
						sum_q     <= '0;
						count_q   <= '0;
						flag_q    <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== verif/caplet_price_checker.sv =====
// checker for the caplet payoff averager: predicts prices and compares output beats
module caplet_price_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        s_tlast,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [47:0] price;
		logic        saturated;
	} price_t;

	// register copies
	logic signed [31:0] strike_q;
	logic [31:0]        accrual_q;
	logic signed [31:0] initial_q;
	logic [5:0]         maturity_q;
	logic [6:0]         tenors_q;

	// path and batch state
	int unsigned  elem_pos;
	bit           past_end;
	logic [63:0]  path_val;
	logic [63:0]  sum_val;
	int unsigned  paths_seen;
	bit           sat_flag;

	price_t prices_due[$];

	assign pending = prices_due.size();

	function automatic int unsigned eff_tenors();
		return (tenors_q > cmcpa_pkg::MAX_TENORS) ? cmcpa_pkg::MAX_TENORS : tenors_q;
	endfunction

	// 1 + r * accrual in Q6.30
	function automatic longint growth_q30(logic signed [31:0] r);
		longint      rv;
		logic [63:0] mag;
		logic [63:0] term;
		rv   = r;
		mag  = (rv < 0) ? -rv : rv;
		term = (mag * {32'd0, accrual_q}) >> 28;
		return (rv < 0) ? (longint'(1) <<< 30) - longint'(term)
		                : (longint'(1) <<< 30) + longint'(term);
	endfunction

	// floor((p << 30) / d), saturating flag raised on quotient wider than 64 bits
	function automatic logic [63:0] div_q30(logic [63:0] p, logic [63:0] d, ref bit sat);
		logic [127:0] q;
		q = ({64'd0, p} << 30) / {64'd0, d};
		if (q[127:64] != 0) begin
			sat = 1;
			return '1;
		end
		return q[63:0];
	endfunction

	task automatic take_rate_beat(logic [63:0] data, bit pend, bit bend);
		longint       diff;
		longint       f;
		logic [127:0] prod;
		logic [63:0]  v;
		logic [63:0]  s;
		logic [63:0]  p;
		longint       base;
		bit           sat;
		price_t       res;
		if (!past_end) begin
			if (elem_pos == 0) begin
				diff = longint'($signed(data[31:0])) - longint'(strike_q);
				path_val = (diff > 0) ? ((diff * {32'd0, accrual_q}) >> 18) : 0;
			end
			if (elem_pos >= maturity_q && elem_pos < eff_tenors()) begin
				f = growth_q30($signed(data[63:32]));
				if (f <= 0) begin
					if (f < 0 && path_val != 0) sat_flag = 1;
					path_val = 0;
				end else begin
					prod = {64'd0, path_val} * {64'd0, f};
					if (prod[127:94] != 0 || prod[93:30] > cmcpa_pkg::PRICE_MAX) begin
						v = cmcpa_pkg::PRICE_MAX;
						sat_flag = 1;
					end else begin
						v = prod[93:30];
					end
					path_val = v;
				end
			end
			if (elem_pos == 63) past_end = 1;
			else elem_pos++;
		end
		if (pend || bend) begin
			if (paths_seen >= cmcpa_pkg::PATH_CAP) begin
				sat_flag = 1;
			end else begin
				s = sum_val + path_val;
				if (s < sum_val) begin
					s = '1;
					sat_flag = 1;
				end
				sum_val = s;
				paths_seen++;
			end
			elem_pos = 0;
			past_end = 0;
			path_val = 0;
		end
		if (bend) begin
			res.price = 0;
			sat = sat_flag;
			if (paths_seen != 0) begin
				base = growth_q30(initial_q);
				if (base <= 0) begin
					res.price = cmcpa_pkg::PRICE_MAX;
					sat = 1;
				end else begin
					p = sum_val / paths_seen;
					for (int i = 0; i < eff_tenors(); i++)
						p = div_q30(p, base, sat);
					if (p > cmcpa_pkg::PRICE_MAX) begin
						p = cmcpa_pkg::PRICE_MAX;
						sat = 1;
					end
					res.price = p[47:0];
				end
			end
			res.saturated = sat;
			prices_due = {prices_due, res};
			sum_val = 0;
			paths_seen = 0;
			sat_flag = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		price_t want;
		if (!arst_n) begin
			strike_q   = 0;
			accrual_q  = cmcpa_pkg::ACCRUAL_RESET;
			initial_q  = 0;
			maturity_q = 0;
			tenors_q   = cmcpa_pkg::TENORS_RESET;
			elem_pos   = 0;
			past_end   = 0;
			path_val   = 0;
			sum_val    = 0;
			paths_seen = 0;
			sat_flag   = 0;
			fail_count = 0;
			prices_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cmcpa_pkg::REG_STRIKE:   strike_q   = cfg_data;
					cmcpa_pkg::REG_ACCRUAL:  accrual_q  = cfg_data;
					cmcpa_pkg::REG_INITIAL:  initial_q  = cfg_data;
					cmcpa_pkg::REG_MATURITY: maturity_q = cfg_data[5:0];
					cmcpa_pkg::REG_TENORS:   tenors_q   = cfg_data[6:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_rate_beat(s_tdata, s_tlast, s_tuser);
			if (m_tvalid && m_tready) begin
				if (prices_due.size() == 0) begin
					$error("unexpected price beat %h", m_tdata);
					fail_count++;
				end else begin
					want = prices_due.pop_front();
					if (m_tdata !== want.price) begin
						$error("price: expected %h actual %h", want.price, m_tdata);
						fail_count++;
					end
					if (m_tuser !== want.saturated) begin
						$error("saturated: expected %0d actual %0d", want.saturated, m_tuser);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== verif/tb_caplet_monte_carlo_payoff_average.sv =====
// testbench top for the caplet payoff averager: stimulus, config phases and verdict
module tb_caplet_monte_carlo_payoff_average;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [63:0] s_tdata = 0;    // [31:0] prev_rate, [63:32] rate
	logic        s_tlast = 0;    // path_end
	logic        s_tuser = 0;    // batch_end
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;        // [47:0] price
	logic        m_tuser;        // saturated
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;

	int  fail_count;
	int  pending;
	int  idle_calls;     // all-beats count bounds the length of each random phase
	int  stall_cycles;
	bit  no_idle;

	// watchdog: a batch of 64 tenors runs its discount divisions with no beat
	localparam int STALL_LIMIT = 40000;

	always #2 clk = ~clk;

	caplet_monte_carlo_payoff_average uut (.*);

	caplet_price_checker chk (.*);

	// receiver idles about 31% except in the quiet stretch
	always @(posedge clk)
		m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 31);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 0;
		@(posedge clk);
	endtask

	// waits until every price has arrived and the block is idle again
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// one rate beat, with random sender gaps
	task automatic send_rate(logic [31:0] prev, logic [31:0] r, bit pend, bit bend);
		idle_calls++;
		while (!no_idle && $urandom_range(99) < 31) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {r, prev};
		s_tlast  <= pend;
		s_tuser  <= bend;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// rate near a typical level, sometimes anything at all
	function automatic logic [31:0] pick_rate();
		if ($urandom_range(9) == 0) return $urandom;
		return $signed($urandom_range(16000000)) - 2000000;
	endfunction

	// one path of given length; batch end closes the last one
	task automatic send_path(int len, bit last_of_batch);
		for (int e = 0; e < len; e++)
			send_rate(pick_rate(), pick_rate(), e == len - 1 && !last_of_batch,
			          e == len - 1 && last_of_batch);
	endtask

	task automatic random_batch(int max_len);
		int npaths;
		npaths = $urandom_range(4, 1);
		for (int p = 0; p < npaths; p++)
			send_path($urandom_range(max_len, 1), p == npaths - 1);
	endtask

	initial begin
		no_idle = 0;
		idle_calls = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: default registers, extremes of the beat fields
		send_rate(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
		send_rate(32'h8000_0000, 32'h8000_0000, 0, 0);
		send_rate(32'h0000_0000, 32'hFFFF_FFFF, 1, 0);
		send_rate(32'h1000_0000, 32'h0100_0000, 0, 1);
		// single-beat batch: a batch end alone closes a one-element path and makes a price
		send_rate(32'h0, 32'h0, 0, 1);
		drain();

		// negative growth clamps the path, short path
		write_reg(cmcpa_pkg::REG_STRIKE, 32'h0);
		write_reg(cmcpa_pkg::REG_ACCRUAL, 32'hFFFF_FFFF);
		write_reg(cmcpa_pkg::REG_INITIAL, 32'h0100_0000);
		write_reg(cmcpa_pkg::REG_MATURITY, 32'd0);
		write_reg(cmcpa_pkg::REG_TENORS, 32'd3);
		send_rate(32'h4000_0000, 32'hC000_0000, 1, 0);
		send_rate(32'h4000_0000, 32'h7000_0000, 0, 0);
		send_rate(32'h0, 32'h7000_0000, 0, 1);
		drain();

		// non-positive discount base, tenors above the limit, long path overrun
		write_reg(cmcpa_pkg::REG_INITIAL, 32'h8000_0000);
		write_reg(cmcpa_pkg::REG_TENORS, 32'd127);
		write_reg(cmcpa_pkg::REG_MATURITY, 32'd63);
		send_path(70, 1);
		drain();

		// zero tenors and zero accrual
		write_reg(cmcpa_pkg::REG_TENORS, 32'd0);
		write_reg(cmcpa_pkg::REG_ACCRUAL, 32'h0);
		write_reg(cmcpa_pkg::REG_INITIAL, 32'h7FFF_FFFF);
		write_reg(cmcpa_pkg::REG_STRIKE, 32'h8000_0000);
		send_rate(32'h7FFF_FFFF, 32'h1, 0, 1);
		drain();

		// random phases with various settings, short tenor counts mostly
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(cmcpa_pkg::REG_STRIKE,
			          (ph % 4 == 0) ? $urandom : $urandom_range(8000000));
			write_reg(cmcpa_pkg::REG_ACCRUAL,
			          (ph % 5 == 0) ? $urandom : $urandom_range(32'h4000_0000));
			write_reg(cmcpa_pkg::REG_INITIAL, (ph % 6 == 5) ? $urandom
			                                     : $signed($urandom_range(8000000)) - 1000000);
			write_reg(cmcpa_pkg::REG_TENORS,
			          (ph == 11) ? 32'd64 : 32'($urandom_range(8, 1)));
			write_reg(cmcpa_pkg::REG_MATURITY, 32'($urandom_range(4)));
			no_idle = (ph == 6);
			while (idle_calls < 60 * (ph + 1) + 60) random_batch(10);
			drain();
		end

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
